[rtl/ptt_pkg.sv]
// Package of the periodic trigger table: sizes, codes and shared types.
package ptt_pkg;

    localparam int NUM_TIMERS = 8;
    localparam int IDX_W      = 3;
    localparam int RT_W       = 18;
    localparam int MS_W       = 16;
    localparam int MASK_W     = 8;

    localparam logic [MS_W-1:0] TRIG_FOREVER = 16'hFFFF;

    localparam logic signed [RT_W-1:0] RT_MAX = 18'sh1FFFF;
    localparam logic signed [RT_W-1:0] RT_MIN = 18'sh20000;

    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_ARM  = 1'b1;

    typedef struct packed {
        logic signed [RT_W-1:0] remaining;
        logic [MS_W-1:0]        period;
        logic [MS_W-1:0]        count;
    } entry_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        entry_t           data;
    } mem_wr_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
    } mem_rd_t;

    typedef struct packed {
        entry_t entry;
        logic   fired;
    } upd_res_t;

endpackage

[rtl/ptt_ram.sv]
// Entry memory of the periodic trigger table: one write port, one registered read port.
module ptt_ram
(
    input  logic             clk,
    input  ptt_pkg::mem_wr_t wr,
    input  ptt_pkg::mem_rd_t rd,
    output ptt_pkg::entry_t  rd_data
);
    import ptt_pkg::*;

    entry_t mem [NUM_TIMERS];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd.en)
        begin
            rd_data_reg <= mem[rd.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/ptt_update.sv]
// Tick update of one timer entry: countdown, single reload and firing count.
module ptt_update
(
    input  ptt_pkg::entry_t     cur,
    input  logic [15:0]         elapsed,
    output ptt_pkg::upd_res_t   res
);
    import ptt_pkg::*;

    logic signed [RT_W:0]   diff;
    logic signed [RT_W-1:0] after_sub;
    logic signed [RT_W:0]   sum;
    logic signed [RT_W-1:0] after_add;
    logic                   fire;

    always_comb
    begin
        diff = {cur.remaining[RT_W-1], cur.remaining} - $signed({3'b000, elapsed});
        // The result only leaves the 18-bit range on the negative side.
        if (diff[RT_W] != diff[RT_W-1])
        begin
            after_sub = RT_MIN;
        end
        else
        begin
            after_sub = diff[RT_W-1:0];
        end

        fire = after_sub[RT_W-1] || (after_sub == '0);

        sum = {after_sub[RT_W-1], after_sub} + $signed({3'b000, cur.period});
        // Adding an unsigned period can only overflow upwards.
        if (sum[RT_W] != sum[RT_W-1])
        begin
            after_add = RT_MAX;
        end
        else
        begin
            after_add = sum[RT_W-1:0];
        end

        res.entry.period = cur.period;
        res.fired        = fire;
        if (fire)
        begin
            res.entry.remaining = after_add;
            if (cur.count != TRIG_FOREVER)
            begin
                res.entry.count = cur.count - 16'd1;
            end
            else
            begin
                res.entry.count = cur.count;
            end
        end
        else
        begin
            res.entry.remaining = after_sub;
            res.entry.count     = cur.count;
        end
    end

endmodule

[rtl/periodic_trigger_table_top.sv]
// Top level of the periodic trigger table: stream ports, sequencer and result register.
// An arm transfer writes its entry on acceptance; a tick transfer has the sequencer walk the
// entries one per cycle (read, update, write back). Either then goes to the finish state, which
// loads the output register, and the next item is taken back in idle. A result waits in the
// output register for the sink; a new result, and with it the input, stalls while it is full.
// rst_n is asynchronous and active low; it clears the state, the active flags and output valid.
module periodic_trigger_table_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // s_tdata from bit 0: timer_index[2:0], elapsed_ms[18:3], first_delay_ms[34:19],
    // period_ms[50:35], repeat_count[66:51], zero fill[71:67]
    input  logic [71:0] s_tdata,
    // s_tuser: func (0 tick, 1 arm)
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata from bit 0: fired_mask[7:0], active_mask[15:8]
    output logic [15:0] m_tdata
);
    import ptt_pkg::*;

    typedef enum logic [2:0]
    {
        ST_IDLE   = 3'b001,
        ST_RUN    = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    state_t              state_reg, state_next;
    logic [IDX_W-1:0]    proc_idx_reg, proc_idx_next;
    logic [MS_W-1:0]     elapsed_reg, elapsed_next;
    logic [MASK_W-1:0]   pend_fired_reg, pend_fired_next;
    logic [NUM_TIMERS-1:0] active_reg, active_next;
    logic                out_valid_reg, out_valid_next;
    logic [MASK_W-1:0]   out_fired_reg, out_fired_next;
    logic [MASK_W-1:0]   out_active_reg, out_active_next;

    logic [IDX_W-1:0]    in_idx;
    logic [MS_W-1:0]     in_elapsed;
    entry_t              in_entry;
    logic                in_accept;
    logic                out_free;

    mem_wr_t             wr;
    mem_rd_t             rd;
    entry_t              rd_data;
    upd_res_t            upd;

    // Unpack the input transfer.
    assign in_idx             = s_tdata[2:0];
    assign in_elapsed         = s_tdata[18:3];
    assign in_entry.remaining = $signed({2'b00, s_tdata[34:19]});
    assign in_entry.period    = s_tdata[50:35];
    assign in_entry.count     = s_tdata[66:51];

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;

    ptt_ram u_ram
    (
        .clk     (clk),
        .wr      (wr),
        .rd      (rd),
        .rd_data (rd_data)
    );

    ptt_update u_update
    (
        .cur     (rd_data),
        .elapsed (elapsed_reg),
        .res     (upd)
    );

    always_comb
    begin
        state_next      = state_reg;
        proc_idx_next   = proc_idx_reg;
        elapsed_next    = elapsed_reg;
        pend_fired_next = pend_fired_reg;
        active_next     = active_reg;
        out_valid_next  = out_valid_reg;
        out_fired_next  = out_fired_reg;
        out_active_next = out_active_reg;

        wr.en   = 1'b0;
        wr.addr = proc_idx_reg;
        wr.data = upd.entry;
        rd.en   = 1'b0;
        rd.addr = proc_idx_reg + 3'd1;

        if (m_tvalid && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    pend_fired_next = '0;
                    if (s_tuser == FUNC_ARM)
                    begin
                        // Every index the field can carry names an entry of the table.
                        wr.en               = 1'b1;
                        wr.addr             = in_idx;
                        wr.data             = in_entry;
                        active_next[in_idx] = (in_entry.count != '0);
                        state_next          = ST_FINISH;
                    end
                    else
                    begin
                        elapsed_next  = in_elapsed;
                        proc_idx_next = '0;
                        rd.en         = 1'b1;
                        rd.addr       = '0;
                        state_next    = ST_RUN;
                    end
                end
            end

            ST_RUN:
            begin
                // Disabled entries are left untouched; their memory contents never matter.
                if (active_reg[proc_idx_reg])
                begin
                    wr.en                         = 1'b1;
                    active_next[proc_idx_reg]     = (upd.entry.count != '0);
                    pend_fired_next[proc_idx_reg] = upd.fired;
                end
                if (proc_idx_reg == IDX_W'(NUM_TIMERS - 1))
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    rd.en         = 1'b1;
                    proc_idx_next = proc_idx_reg + 3'd1;
                end
            end

            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_fired_next  = pend_fired_reg;
                    out_active_next = active_reg;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            active_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        proc_idx_reg   <= proc_idx_next;
        elapsed_reg    <= elapsed_next;
        pend_fired_reg <= pend_fired_next;
        out_fired_reg  <= out_fired_next;
        out_active_reg <= out_active_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_active_reg, out_fired_reg};

endmodule
